// File: src/imvm_pkg.sv
package imvm_pkg;

    // Fixed field widths
    localparam int ACC_W      = 32;
    localparam int ADDR_W     = 16;
    localparam int ACT_W      = 8;
    localparam int WGT_W      = 8;
    localparam int RES_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;
    localparam int STRIDE_W   = 5;
    localparam int QUEUE_DEPTH = 2;

    // Register map
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_OFFSET     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_OFFSET    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_MULTIPLIER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_SHIFT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CLAMP_LOW        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CLAMP_HIGH       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_ENABLE      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_STRIDE    = 3'd7;

    // Configuration register set
    typedef struct packed {
        logic signed [8:0]          input_offset;
        logic signed [7:0]          output_offset;
        logic [30:0]                scale_multiplier;
        logic signed [5:0]          scale_shift;
        logic signed [7:0]          clamp_low;
        logic signed [7:0]          clamp_high;
        logic                       bias_enable;
        logic [STRIDE_W-1:0]        output_stride;
    } cfg_t;

    // Finished row sum waiting for requantising
    typedef struct packed {
        logic [ACC_W-1:0]  acc;
        logic [ADDR_W-1:0] addr;
    } row_word_t;

endpackage

// File: src/int8_vec_mat_mult_requant_core.sv
// Channel   Handshake                    Word
// item      item_valid / item_stall      activation, weight, bias_value,
//                                        first_column, last_column, last_row
// result    result_valid / result_stall  result_value, result_address
// config    cfg_write                    cfg_index, cfg_data
//
// One item is taken per cycle while item_stall is low; the single MAC in the
// front sets that figure. A row result passes through the two-entry queue, four
// requantise stages (shift, multiply, round, shift-round) and the output register.
// item_stall rises while the queue between MAC and requantiser is full.
// Reset clears accumulator, row counter, queue and pipeline valids at once.
module int8_vec_mat_mult_requant_core
    import imvm_pkg::*;
#(
    parameter int MAX_ROWS = 4096
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_stall,
    input  logic signed [ACT_W-1:0]      activation,
    input  logic signed [WGT_W-1:0]      weight,
    input  logic signed [ACC_W-1:0]      bias_value,
    input  logic                         first_column,
    input  logic                         last_column,
    input  logic                         last_row,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic signed [RES_W-1:0]      result_value,
    output logic [ADDR_W-1:0]            result_address,
    input  logic                         cfg_write,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data
);

    cfg_t      cfg_reg;
    logic      accept;
    logic      push;
    row_word_t push_word;
    logic      q_full, q_empty, q_pop;
    row_word_t q_word;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.input_offset     <= '0;
            cfg_reg.output_offset    <= '0;
            cfg_reg.scale_multiplier <= 31'h4000_0000;
            cfg_reg.scale_shift      <= '0;
            cfg_reg.clamp_low        <= 8'sh80;
            cfg_reg.clamp_high       <= 8'sh7F;
            cfg_reg.bias_enable      <= 1'b0;
            cfg_reg.output_stride    <= 5'd1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_INPUT_OFFSET:     cfg_reg.input_offset     <= cfg_data[8:0];
                REG_OUTPUT_OFFSET:    cfg_reg.output_offset    <= cfg_data[7:0];
                REG_SCALE_MULTIPLIER: cfg_reg.scale_multiplier <= cfg_data[30:0];
                REG_SCALE_SHIFT:      cfg_reg.scale_shift      <= cfg_data[5:0];
                REG_CLAMP_LOW:        cfg_reg.clamp_low        <= cfg_data[7:0];
                REG_CLAMP_HIGH:       cfg_reg.clamp_high       <= cfg_data[7:0];
                REG_BIAS_ENABLE:      cfg_reg.bias_enable      <= cfg_data[0];
                REG_OUTPUT_STRIDE:    cfg_reg.output_stride    <= cfg_data[STRIDE_W-1:0];
                default: ;
            endcase
        end
    end

    assign item_stall = q_full;
    assign accept     = item_valid && !item_stall;

    // Front: MAC and row addressing
    imvm_front #(
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .accept       (accept),
        .activation   (activation),
        .weight       (weight),
        .bias_value   (bias_value),
        .first_column (first_column),
        .last_column  (last_column),
        .last_row     (last_row),
        .push         (push),
        .push_word    (push_word)
    );

    // Queue of finished row sums
    imvm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (q_pop),
        .full      (q_full),
        .empty     (q_empty),
        .head_word (q_word)
    );

    // Back: requantise pipeline and output register
    imvm_requant u_requant (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .q_empty        (q_empty),
        .q_word         (q_word),
        .q_pop          (q_pop),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .result_value   (result_value),
        .result_address (result_address)
    );

endmodule

// File: src/imvm_front.sv
module imvm_front
    import imvm_pkg::*;
#(
    parameter int MAX_ROWS = 4096
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cfg_t                     cfg,
    input  logic                     accept,
    input  logic signed [ACT_W-1:0]  activation,
    input  logic signed [WGT_W-1:0]  weight,
    input  logic signed [ACC_W-1:0]  bias_value,
    input  logic                     first_column,
    input  logic                     last_column,
    input  logic                     last_row,
    output logic                     push,
    output row_word_t                push_word
);

    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int PROD_W = ROW_W + STRIDE_W;

    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic [ACC_W-1:0]     acc_base;
    logic signed [9:0]    act_off;
    logic signed [17:0]   mac_prod;
    logic [PROD_W-1:0]    addr_prod;

    // Row start: load bias or zero, otherwise carry on
    always_comb
    begin
        if (first_column)
            acc_base = cfg.bias_enable ? bias_value : '0;
        else
            acc_base = acc_reg;
    end

    // Single MAC, wraps in 32 bits
    assign act_off  = 10'(activation) + 10'(cfg.input_offset);
    assign mac_prod = act_off * 18'(weight);
    assign acc_next = acc_base + ACC_W'(mac_prod);

    // Row counter, restarts after the final row or after row MAX_ROWS-1
    always_comb
    begin
        if (last_row || (row_reg == ROW_W'(MAX_ROWS - 1)))
            row_next = '0;
        else
            row_next = row_reg + 1'b1;
    end

    assign addr_prod = row_reg * PROD_W'(cfg.output_stride);

    assign push           = accept && last_column;
    assign push_word.acc  = acc_next;
    assign push_word.addr = ADDR_W'(addr_prod);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            acc_reg <= acc_next;
            if (last_column)
                row_reg <= row_next;
        end
    end

endmodule

// File: src/imvm_queue.sv
module imvm_queue
    import imvm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  row_word_t push_word,
    input  logic      pop,
    output logic      full,
    output logic      empty,
    output row_word_t head_word
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    row_word_t        mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign head_word = mem[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_word;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// File: src/imvm_requant.sv
module imvm_requant
    import imvm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cfg_t                     cfg,
    input  logic                     q_empty,
    input  row_word_t                q_word,
    output logic                     q_pop,
    output logic                     result_valid,
    input  logic                     result_stall,
    output logic signed [RES_W-1:0]  result_value,
    output logic [ADDR_W-1:0]        result_address
);

    logic               advance;
    logic [4:0]         left;
    logic [5:0]         neg_shift;
    logic [4:0]         right;

    // Stage valids
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, out_valid_reg;

    // Stage payloads
    logic [ACC_W-1:0]          s1_x_reg;
    logic signed [63:0]        s2_prod_reg;
    logic signed [ACC_W-1:0]   s3_y_reg;
    logic signed [ACC_W-1:0]   s4_q_reg;
    logic [ADDR_W-1:0]         s1_addr_reg, s2_addr_reg, s3_addr_reg, s4_addr_reg;
    logic signed [RES_W-1:0]   out_value_reg;
    logic [ADDR_W-1:0]         out_addr_reg;

    logic signed [63:0]        rnd_sum;
    logic [ACC_W-1:0]          mask;
    logic [ACC_W-1:0]          rem;
    logic [ACC_W-1:0]          thr;
    logic signed [ACC_W-1:0]   q_shift;
    logic signed [ACC_W-1:0]   q_next;
    logic signed [ACC_W:0]     off_sum;
    logic signed [ACC_W:0]     clamped;

    // Whole pipeline moves when the output register can take a word
    assign advance = !out_valid_reg || !result_stall;
    assign q_pop   = advance && !q_empty;

    // Shift split; a shift of -32 counts as 31 right
    assign left      = cfg.scale_shift[5] ? 5'd0 : cfg.scale_shift[4:0];
    assign neg_shift = 6'(-cfg.scale_shift);
    assign right     = !cfg.scale_shift[5] ? 5'd0 :
                       (neg_shift[5] ? 5'd31 : neg_shift[4:0]);

    // Doubling high multiply with round half up
    assign rnd_sum = s2_prod_reg + 64'sd1073741824;

    // Rounding right shift, ties away from zero
    assign mask    = (32'd1 << right) - 32'd1;
    assign rem     = s3_y_reg & mask;
    assign q_shift = s3_y_reg >>> right;
    assign thr     = (mask >> 1) + ACC_W'(q_shift[ACC_W-1]);
    assign q_next  = (rem > thr) ? q_shift + 32'sd1 : q_shift;

    // Output offset and clamp, low bound first
    assign off_sum = 33'(s4_q_reg) + 33'(cfg.output_offset);
    always_comb
    begin
        clamped = off_sum;
        if (clamped < 33'(cfg.clamp_low))
            clamped = 33'(cfg.clamp_low);
        if (clamped > 33'(cfg.clamp_high))
            clamped = 33'(cfg.clamp_high);
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= !q_empty;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            out_valid_reg <= s4_valid_reg;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_x_reg      <= q_word.acc << left;
            s1_addr_reg   <= q_word.addr;
            s2_prod_reg   <= $signed(s1_x_reg) * $signed({1'b0, cfg.scale_multiplier});
            s2_addr_reg   <= s1_addr_reg;
            s3_y_reg      <= rnd_sum[62:31];
            s3_addr_reg   <= s2_addr_reg;
            s4_q_reg      <= q_next;
            s4_addr_reg   <= s3_addr_reg;
            out_value_reg <= clamped[RES_W-1:0];
            out_addr_reg  <= s4_addr_reg;
        end
    end

    assign result_valid   = out_valid_reg;
    assign result_value   = out_value_reg;
    assign result_address = out_addr_reg;

endmodule

// File: tb/int8_vec_mat_mult_requant_core_tb.sv
`timescale 1ns / 1ps

module int8_vec_mat_mult_requant_core_tb
    import imvm_pkg::*;
();

    localparam int ROW_LIMIT = 4096;

    // One element word as the sender offers it
    typedef struct packed {
        logic signed [ACT_W-1:0] act;
        logic signed [WGT_W-1:0] wgt;
        logic signed [ACC_W-1:0] bias;
        logic                    first_col;
        logic                    last_col;
        logic                    final_row;
    } elem_t;

    // Requantised row result with its address
    typedef struct packed {
        logic signed [RES_W-1:0] value;
        logic [ADDR_W-1:0]       address;
    } requant_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    item_valid = 1'b0;
    logic                    item_stall;
    logic signed [ACT_W-1:0] activation = '0;
    logic signed [WGT_W-1:0] weight = '0;
    logic signed [ACC_W-1:0] bias_value = '0;
    logic                    first_column = 1'b0;
    logic                    last_column = 1'b0;
    logic                    last_row = 1'b0;
    logic                    result_valid;
    logic                    result_stall = 1'b0;
    logic signed [RES_W-1:0] result_value;
    logic [ADDR_W-1:0]       result_address;
    logic                    cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;

    // Predictor state and register copy
    cfg_t        regs_now;
    int          acc_model;
    int unsigned row_model;
    requant_t    requant_due [$];

    // Idling controls, percentages and stall lengths
    int gap_pct = 0;
    int stall_pct = 0;
    int hold_cycles = 0;
    int stall_left = 0;

    int err_count = 0;
    int items_taken = 0;
    int results_seen = 0;
    int settings_used = 0;
    requant_t want_r;

    always #1 clk = ~clk;

    int8_vec_mat_mult_requant_core #(
        .MAX_ROWS(ROW_LIMIT)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .activation     (activation),
        .weight         (weight),
        .bias_value     (bias_value),
        .first_column   (first_column),
        .last_column    (last_column),
        .last_row       (last_row),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .result_value   (result_value),
        .result_address (result_address),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // MAC and requantise prediction for one accepted element word
    function automatic void mac_step(input elem_t e, output bit emits, output requant_t res);
        int          term;
        logic [31:0] shifted;
        longint      prod;
        int          hm;
        int          q;
        int unsigned msk;
        int unsigned rem;
        int unsigned thr;
        int          sh;
        int          lsh;
        int          rsh;
        longint      z;
        int unsigned addr;
        res = '0;
        if (e.first_col)
            acc_model = regs_now.bias_enable ? int'($signed(e.bias)) : 0;
        term = (int'($signed(e.act)) + int'($signed(regs_now.input_offset)))
               * int'($signed(e.wgt));
        acc_model = acc_model + term;
        emits = e.last_col;
        if (!e.last_col)
            return;
        // shift of -32 saturates to a right shift of 31
        sh = int'($signed(regs_now.scale_shift));
        lsh = (sh > 0) ? sh : 0;
        rsh = (sh < 0) ? -sh : 0;
        if (rsh > 31)
            rsh = 31;
        shifted = acc_model << lsh;
        // rounding doubling high multiply
        prod = longint'($signed(shifted)) * longint'(regs_now.scale_multiplier)
               + 64'sd1073741824;
        hm = int'(prod >>> 31);
        // rounding right shift, ties away from zero
        msk = (32'd1 << rsh) - 32'd1;
        rem = hm & msk;
        q = hm >>> rsh;
        thr = msk >> 1;
        if (q < 0)
            thr++;
        if (rem > thr)
            q++;
        // offset, then lower bound before upper
        z = longint'(q) + longint'($signed(regs_now.output_offset));
        if (z < longint'($signed(regs_now.clamp_low)))
            z = longint'($signed(regs_now.clamp_low));
        if (z > longint'($signed(regs_now.clamp_high)))
            z = longint'($signed(regs_now.clamp_high));
        res.value = z[7:0];
        addr = row_model * regs_now.output_stride;
        res.address = addr[15:0];
        if (e.final_row)
            row_model = 0;
        else
        begin
            row_model++;
            if (row_model >= ROW_LIMIT)
                row_model = 0;
        end
    endfunction

    function automatic cfg_t make_regs(int in_off, int out_off, int unsigned mult, int shift,
                                       int lo, int hi, int bias_on, int stride);
        cfg_t r;
        r.input_offset     = 9'(in_off);
        r.output_offset    = 8'(out_off);
        r.scale_multiplier = 31'(mult);
        r.scale_shift      = 6'(shift);
        r.clamp_low        = 8'(lo);
        r.clamp_high       = 8'(hi);
        r.bias_enable      = 1'(bias_on);
        r.output_stride    = 5'(stride);
        return r;
    endfunction

    function automatic elem_t make_elem(int a, int w, int b, bit f, bit l, bit lr);
        elem_t e;
        e.act       = 8'(a);
        e.wgt       = 8'(w);
        e.bias      = 32'(b);
        e.first_col = f;
        e.last_col  = l;
        e.final_row = lr;
        return e;
    endfunction

    function automatic logic signed [7:0] rand_int8();
        case ($urandom_range(0, 7))
            0: return 8'sh80;
            1: return 8'sh7f;
            2: return 8'sh00;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic signed [31:0] rand_bias();
        case ($urandom_range(0, 7))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2, 3: return 32'($urandom);
            default: return 32'($urandom_range(0, 4000)) - 32'd2000;
        endcase
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 10;
            2: return 30;
            default: return 60;
        endcase
    endfunction

    function automatic cfg_t random_regs();
        cfg_t r;
        logic signed [7:0] t;
        if ($urandom_range(0, 9) == 0)
            r.input_offset = 9'($urandom);
        else
            r.input_offset = 9'(int'($urandom_range(0, 256)) - 128);
        r.output_offset = 8'($urandom);
        case ($urandom_range(0, 5))
            0: r.scale_multiplier = '0;
            1: r.scale_multiplier = 31'h7fff_ffff;
            2: r.scale_multiplier = 31'h4000_0000;
            default: r.scale_multiplier = 31'($urandom);
        endcase
        if ($urandom_range(0, 7) == 0)
            r.scale_shift = 6'($urandom);
        else
            r.scale_shift = 6'(int'($urandom_range(0, 40)) - 32);
        r.clamp_low  = 8'($urandom);
        r.clamp_high = 8'($urandom);
        case ($urandom_range(0, 3))
            0:
            begin
                r.clamp_low  = 8'sh80;
                r.clamp_high = 8'sh7f;
            end
            1: ; // bounds may cross
            default:
            begin
                if ($signed(r.clamp_low) > $signed(r.clamp_high))
                begin
                    t = r.clamp_low;
                    r.clamp_low = r.clamp_high;
                    r.clamp_high = t;
                end
            end
        endcase
        r.bias_enable = 1'($urandom);
        if ($urandom_range(0, 7) == 0)
            r.output_stride = 5'($urandom);
        else
            r.output_stride = 5'($urandom_range(1, 16));
        return r;
    endfunction

    // Offer one element word and hold it until taken
    task automatic issue_element(input elem_t e);
        bit       emits;
        requant_t r;
        item_valid   <= 1'b1;
        activation   <= e.act;
        weight       <= e.wgt;
        bias_value   <= e.bias;
        first_column <= e.first_col;
        last_column  <= e.last_col;
        last_row     <= e.final_row;
        do
            @(posedge clk);
        while (item_stall);
        mac_step(e, emits, r);
        if (emits)
            requant_due.push_back(r);
        items_taken++;
    endtask

    task automatic feed_element(input elem_t e);
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        issue_element(e);
    endtask

    // Wait for every row result, then let the pipeline empty
    task automatic settle();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (requant_due.size() != 0);
        repeat (12) @(posedge clk);
    endtask

    task automatic load_regs(input cfg_t r);
        logic [CFG_DATA_W-1:0] img [8];
        settle();
        img[REG_INPUT_OFFSET]     = CFG_DATA_W'($unsigned(r.input_offset));
        img[REG_OUTPUT_OFFSET]    = CFG_DATA_W'($unsigned(r.output_offset));
        img[REG_SCALE_MULTIPLIER] = CFG_DATA_W'(r.scale_multiplier);
        img[REG_SCALE_SHIFT]      = CFG_DATA_W'($unsigned(r.scale_shift));
        img[REG_CLAMP_LOW]        = CFG_DATA_W'($unsigned(r.clamp_low));
        img[REG_CLAMP_HIGH]       = CFG_DATA_W'($unsigned(r.clamp_high));
        img[REG_BIAS_ENABLE]      = CFG_DATA_W'(r.bias_enable);
        img[REG_OUTPUT_STRIDE]    = CFG_DATA_W'(r.output_stride);
        for (int i = 0; i < 8; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= img[i];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        regs_now = r;
        settings_used++;
    endtask

    // Well-formed row with random content, now and then broken
    task automatic random_row(input int max_len);
        elem_t e;
        int    len;
        len = $urandom_range(1, max_len);
        for (int k = 0; k < len; k++)
        begin
            e.act       = rand_int8();
            e.wgt       = rand_int8();
            e.bias      = rand_bias();
            e.first_col = (k == 0);
            e.last_col  = (k == len - 1);
            e.final_row = e.last_col ? ($urandom_range(0, 5) == 0)
                                     : ($urandom_range(0, 15) == 0);
            if ($urandom_range(0, 19) == 0)
                e.first_col = !e.first_col;
            if ($urandom_range(0, 24) == 0)
                e.last_col = !e.last_col;
            feed_element(e);
        end
    endtask

    // Result side: check each taken word, then pick the next stall
    always @(posedge clk)
    begin
        if (result_valid && !result_stall)
        begin
            if (requant_due.size() == 0)
            begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected result word: value %0d address %0d",
                             result_value, result_address);
            end
            else
            begin
                want_r = requant_due.pop_front();
                if (result_value !== want_r.value || result_address !== want_r.address)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display("row result %0d: expected value %0d address %0d, got %0d / %0d",
                                 results_seen, want_r.value, want_r.address,
                                 result_value, result_address);
                end
            end
            results_seen++;
        end
        if (hold_cycles > 0)
        begin
            stall_left = hold_cycles;
            hold_cycles = 0;
        end
        else if (stall_left == 0 && stall_pct > 0 && $urandom_range(0, 99) < stall_pct)
            stall_left = $urandom_range(1, 11);
        if (stall_left > 0)
        begin
            result_stall <= 1'b1;
            stall_left--;
        end
        else
            result_stall <= 1'b0;
    end

    // Reset register values, single-element rows at the extremes
    task automatic test_reset_state();
        issue_element(make_elem(127, 127, 0, 1'b1, 1'b1, 1'b0));
        issue_element(make_elem(-128, 127, 0, 1'b1, 1'b1, 1'b0));
        issue_element(make_elem(-128, -128, 0, 1'b1, 1'b1, 1'b1));
    endtask

    task automatic test_directed_cases();
        // widest offset, full multiplier, largest left shift, bias extremes
        load_regs(make_regs(-256, -128, 32'h7fff_ffff, 31, -128, 127, 1, 31));
        issue_element(make_elem(-128, -128, 32'h7fff_ffff, 1'b1, 1'b1, 1'b1));
        issue_element(make_elem(1, 2, int'(32'h8000_0000), 1'b1, 1'b0, 1'b0));
        issue_element(make_elem(127, -128, 0, 1'b0, 1'b0, 1'b0));
        issue_element(make_elem(-1, 127, 0, 1'b0, 1'b1, 1'b0));
        // zero multiplier, saturated right shift, crossed bounds, zero stride
        load_regs(make_regs(255, 127, 0, -32, 100, -100, 0, 0));
        issue_element(make_elem(0, 0, 0, 1'b1, 1'b1, 1'b0));
        issue_element(make_elem(127, 127, 0, 1'b1, 1'b1, 1'b1));
        // rounding ties, missing and repeated first column, stray last_row
        load_regs(make_regs(128, 0, 32'h4000_0000, -1, -128, 127, 1, 16));
        issue_element(make_elem(-128, 0, 1, 1'b1, 1'b1, 1'b0));
        issue_element(make_elem(-127, 1, 3, 1'b1, 1'b1, 1'b0));
        issue_element(make_elem(5, 5, 0, 1'b0, 1'b0, 1'b0));
        issue_element(make_elem(3, -7, 0, 1'b0, 1'b0, 1'b1));
        issue_element(make_elem(0, 0, 777, 1'b1, 1'b0, 1'b0));
        issue_element(make_elem(-5, 9, 0, 1'b0, 1'b1, 1'b0));
        // smallest multiplier with the deepest regular right shift
        load_regs(make_regs(-128, -1, 1, -31, -128, 127, 1, 1));
        issue_element(make_elem(127, -128, int'(32'h8000_0000), 1'b1, 1'b1, 1'b0));
        issue_element(make_elem(-128, 127, 32'h7fff_ffff, 1'b1, 1'b1, 1'b1));
    endtask

    // Long receiver hold-off while rows keep arriving
    task automatic test_output_backpressure();
        load_regs(random_regs());
        gap_pct = 0;
        stall_pct = 0;
        hold_cycles = 200;
        repeat (40) random_row(1);
        repeat (10) random_row(4);
    endtask

    // Sender stops until the result side has caught up
    task automatic test_sender_pause();
        gap_pct = 20;
        stall_pct = 20;
        repeat (10) random_row(6);
        settle();
        repeat (10) random_row(6);
    endtask

    // Long run of single-element rows, row counter climbs with wide stride
    task automatic test_long_row_run();
        elem_t e;
        load_regs(make_regs(0, 0, 32'h4000_0000, -4, -128, 127, 1, 31));
        gap_pct = 0;
        stall_pct = 5;
        for (int k = 0; k < 200; k++)
        begin
            e = make_elem(rand_int8(), rand_int8(), rand_bias(), 1'b1, 1'b1, 1'b0);
            feed_element(e);
        end
    endtask

    task automatic test_random_settings();
        int budget;
        for (int p = 0; p < 8; p++)
        begin
            if (p == 0)
                load_regs(make_regs(-128, -128, 32'h7fff_ffff, -31, -128, 127, 1, 16));
            else if (p == 1)
                load_regs(make_regs(128, 127, 0, 31, -128, 127, 0, 1));
            else
                load_regs(random_regs());
            gap_pct = pick_pct();
            stall_pct = pick_pct();
            budget = items_taken + 90;
            while (items_taken < budget)
                random_row(($urandom_range(0, 9) == 0) ? 32 : 8);
        end
    endtask

    // Closing stretch at full rate on both sides
    task automatic test_final_stream();
        int budget;
        load_regs(random_regs());
        gap_pct = 0;
        stall_pct = 0;
        budget = items_taken + 150;
        while (items_taken < budget)
            random_row(8);
    endtask

    initial
    begin
        regs_now = make_regs(0, 0, 32'h4000_0000, 0, -128, 127, 0, 1);
        acc_model = 0;
        row_model = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_state();
        test_directed_cases();
        test_output_backpressure();
        test_sender_pause();
        test_long_row_run();
        test_random_settings();
        test_final_stream();
        settle();
        $display("covered %0d element words, %0d row results, %0d register settings",
                 items_taken, results_seen, settings_used);
        $display("incl. long result hold-off, sender pause and a long run of rows");
        if (err_count == 0 && requant_due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: filelist.f
src/imvm_pkg.sv
src/imvm_front.sv
src/imvm_queue.sv
src/imvm_requant.sv
src/int8_vec_mat_mult_requant_core.sv
tb/int8_vec_mat_mult_requant_core_tb.sv
